[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the sphere-to-shape distance block.
// Define NO_ASSERTIONS to compile the macros to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/s2sd_pkg.sv]
// Shared types, widths and helper functions of the sphere-to-shape distance block.
// No dependencies.
package s2sd_pkg;

   localparam int DEF_COORD_WIDTH = 32;
   localparam int VEC_W           = 32;
   localparam int EXT_W           = 31;
   localparam int RES_W           = 35;
   localparam int RAD_W           = 64;
   localparam int ROOT_W          = 32;
   localparam int GEOM_STAGES     = 9;
   localparam int SUMSQ_STAGES    = 2;

   localparam logic signed [VEC_W-1:0] UNIT_Q30  = 32'sh4000_0000;
   localparam logic signed [34:0]      UNIT_WIDE = 35'sh0_4000_0000;
   localparam logic signed [37:0]      PROJ_LIM  = 38'sh1_FFFF_FFFF;

   typedef enum logic [1:0] {
      KIND_SPHERE = 2'd0,
      KIND_PLATE  = 2'd1,
      KIND_HOLE   = 2'd2,
      KIND_CYL    = 2'd3
   } kind_type;

   typedef struct packed {
      logic                    valid;
      logic signed [RES_W-1:0] r0;
      logic signed [RES_W-1:0] r1;
      logic signed [RES_W-1:0] r2;
   } resid_type;

   typedef struct packed {
      logic             valid;
      logic             sat;
      logic [RAD_W-1:0] radicand;
   } rad_type;

   typedef struct packed {
      logic              valid;
      logic              sat;
      logic [ROOT_W-1:0] root;
   } root_type;

   // Saturate a vector component to the range of a unit value.
   function automatic logic signed [VEC_W-1:0] clip_unit(input logic signed [34:0] x);
      logic signed [VEC_W-1:0] res;
      if (x > UNIT_WIDE) begin
         res = UNIT_Q30;
      end else if (x < -UNIT_WIDE) begin
         res = -UNIT_Q30;
      end else begin
         res = x[VEC_W-1:0];
      end
      return res;
   endfunction

   // Clamp a coordinate to plus or minus a half extent.
   function automatic logic signed [VEC_W-1:0] clip_half(input logic signed [37:0] x,
                                                        input logic [EXT_W-2:0] h);
      logic signed [37:0]      hs;
      logic signed [VEC_W-1:0] res;
      hs = signed'({8'b0, h});
      if (x > hs) begin
         res = hs[VEC_W-1:0];
      end else if (x < -hs) begin
         res = 32'(-hs);
      end else begin
         res = x[VEC_W-1:0];
      end
      return res;
   endfunction

endpackage

[hw/rtl/s2sd_geom.sv]
// Geometry pipeline: projection, clamping and reconstruction of the closest point.
// Depends on s2sd_pkg.
module s2sd_geom #(
   parameter int COORD_WIDTH = s2sd_pkg::DEF_COORD_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [1:0]          req_type,
   input  logic [31:0]         offset_x,
   input  logic [31:0]         offset_y,
   input  logic [31:0]         offset_z,
   input  logic [31:0]         normal_x,
   input  logic [31:0]         normal_y,
   input  logic [31:0]         normal_z,
   input  logic [31:0]         inplane_x,
   input  logic [31:0]         inplane_y,
   input  logic [31:0]         inplane_z,
   input  logic [30:0]         extent_a,
   input  logic [30:0]         extent_b,
   output s2sd_pkg::resid_type resid
);
   import s2sd_pkg::*;

   localparam int CW_EFF = (COORD_WIDTH < VEC_W) ? COORD_WIDTH : VEC_W;

   logic [31:0] off_a [3];
   logic [31:0] nrm_a [3];
   logic [31:0] inp_a [3];

   assign off_a[0] = offset_x;
   assign off_a[1] = offset_y;
   assign off_a[2] = offset_z;
   assign nrm_a[0] = normal_x;
   assign nrm_a[1] = normal_y;
   assign nrm_a[2] = normal_z;
   assign inp_a[0] = inplane_x;
   assign inp_a[1] = inplane_y;
   assign inp_a[2] = inplane_z;

   logic [GEOM_STAGES-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[GEOM_STAGES-2:0], start};
      end
   end

   // Stage 1: input capture with sign extension and unit clamping.
   kind_type                kind1_ff;
   logic signed [VEC_W-1:0] d1_ff [3];
   logic signed [VEC_W-1:0] n1_ff [3];
   logic signed [VEC_W-1:0] u1_ff [3];
   logic [EXT_W-2:0]        ha1_ff, hb1_ff;

   always_ff @(posedge clock) begin
      kind1_ff <= kind_type'(req_type);
      ha1_ff   <= extent_a[EXT_W-1:1];
      hb1_ff   <= extent_b[EXT_W-1:1];
      for (int i = 0; i < 3; i++) begin
         d1_ff[i] <= 32'(signed'(off_a[i][CW_EFF-1:0]));
         n1_ff[i] <= clip_unit(35'(signed'(nrm_a[i])));
         u1_ff[i] <= clip_unit(35'(signed'(inp_a[i])));
      end
   end

   // Stage 2: products for the axial dot product and for v = n cross u.
   kind_type                kind2_ff;
   logic signed [VEC_W-1:0] d2_ff [3];
   logic signed [VEC_W-1:0] n2_ff [3];
   logic signed [VEC_W-1:0] u2_ff [3];
   logic [EXT_W-2:0]        ha2_ff, hb2_ff;
   logic signed [63:0]      pdn2_ff [3];
   logic signed [63:0]      cra2_ff [3];
   logic signed [63:0]      crb2_ff [3];

   always_ff @(posedge clock) begin
      kind2_ff <= kind1_ff;
      ha2_ff   <= ha1_ff;
      hb2_ff   <= hb1_ff;
      for (int i = 0; i < 3; i++) begin
         d2_ff[i]   <= d1_ff[i];
         n2_ff[i]   <= n1_ff[i];
         u2_ff[i]   <= u1_ff[i];
         pdn2_ff[i] <= 64'(d1_ff[i]) * 64'(n1_ff[i]);
      end
      cra2_ff[0] <= 64'(n1_ff[1]) * 64'(u1_ff[2]);
      crb2_ff[0] <= 64'(n1_ff[2]) * 64'(u1_ff[1]);
      cra2_ff[1] <= 64'(n1_ff[2]) * 64'(u1_ff[0]);
      crb2_ff[1] <= 64'(n1_ff[0]) * 64'(u1_ff[2]);
      cra2_ff[2] <= 64'(n1_ff[0]) * 64'(u1_ff[1]);
      crb2_ff[2] <= 64'(n1_ff[1]) * 64'(u1_ff[0]);
   end

   // Stage 3: axial coordinate t, clamped for a cylinder, and v.
   logic signed [RES_W-1:0] t3_in, sel3_in;
   logic signed [64:0]      vdiff [3];
   logic signed [VEC_W-1:0] v3_in [3];

   always_comb begin
      t3_in = 35'(pdn2_ff[0] >>> 30) + 35'(pdn2_ff[1] >>> 30) + 35'(pdn2_ff[2] >>> 30);
      for (int k = 0; k < 3; k++) begin
         vdiff[k] = 65'(cra2_ff[k]) - 65'(crb2_ff[k]);
         v3_in[k] = clip_unit(35'(vdiff[k] >>> 30));
      end
      if (kind2_ff == KIND_CYL) begin
         sel3_in = 35'(clip_half(38'(t3_in), ha2_ff));
      end else begin
         sel3_in = t3_in;
      end
   end

   kind_type                kind3_ff;
   logic signed [VEC_W-1:0] d3_ff [3];
   logic signed [VEC_W-1:0] n3_ff [3];
   logic signed [VEC_W-1:0] u3_ff [3];
   logic signed [VEC_W-1:0] v3_ff [3];
   logic [EXT_W-2:0]        ha3_ff, hb3_ff;
   logic signed [RES_W-1:0] sel3_ff;

   always_ff @(posedge clock) begin
      kind3_ff <= kind2_ff;
      ha3_ff   <= ha2_ff;
      hb3_ff   <= hb2_ff;
      sel3_ff  <= sel3_in;
      for (int i = 0; i < 3; i++) begin
         d3_ff[i] <= d2_ff[i];
         n3_ff[i] <= n2_ff[i];
         u3_ff[i] <= u2_ff[i];
         v3_ff[i] <= v3_in[i];
      end
   end

   // Stage 4: normal scaled by the axial coordinate.
   kind_type                kind4_ff;
   logic signed [VEC_W-1:0] d4_ff [3];
   logic signed [VEC_W-1:0] u4_ff [3];
   logic signed [VEC_W-1:0] v4_ff [3];
   logic [EXT_W-2:0]        ha4_ff, hb4_ff;
   logic signed [66:0]      q4_ff [3];

   always_ff @(posedge clock) begin
      kind4_ff <= kind3_ff;
      ha4_ff   <= ha3_ff;
      hb4_ff   <= hb3_ff;
      for (int i = 0; i < 3; i++) begin
         d4_ff[i] <= d3_ff[i];
         u4_ff[i] <= u3_ff[i];
         v4_ff[i] <= v3_ff[i];
         q4_ff[i] <= 67'(n3_ff[i]) * 67'(sel3_ff);
      end
   end

   // Stage 5: in-plane projection for plates, residual for a cylinder.
   logic signed [36:0]      f5 [3];
   logic signed [37:0]      pd5 [3];
   logic signed [33:0]      p5_in [3];
   logic signed [RES_W-1:0] rc5_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         f5[i]     = 37'(q4_ff[i] >>> 30);
         pd5[i]    = 38'(d4_ff[i]) - 38'(f5[i]);
         rc5_in[i] = 35'(f5[i]) - 35'(d4_ff[i]);
         if (pd5[i] > PROJ_LIM) begin
            p5_in[i] = PROJ_LIM[33:0];
         end else if (pd5[i] < -PROJ_LIM) begin
            p5_in[i] = 34'(-PROJ_LIM);
         end else begin
            p5_in[i] = pd5[i][33:0];
         end
      end
   end

   kind_type                kind5_ff;
   logic signed [VEC_W-1:0] d5_ff [3];
   logic signed [VEC_W-1:0] u5_ff [3];
   logic signed [VEC_W-1:0] v5_ff [3];
   logic [EXT_W-2:0]        ha5_ff, hb5_ff;
   logic signed [33:0]      p5_ff [3];
   logic signed [RES_W-1:0] rc5_ff [3];

   always_ff @(posedge clock) begin
      kind5_ff <= kind4_ff;
      ha5_ff   <= ha4_ff;
      hb5_ff   <= hb4_ff;
      for (int i = 0; i < 3; i++) begin
         d5_ff[i]  <= d4_ff[i];
         u5_ff[i]  <= u4_ff[i];
         v5_ff[i]  <= v4_ff[i];
         p5_ff[i]  <= p5_in[i];
         rc5_ff[i] <= rc5_in[i];
      end
   end

   // Stage 6: projection products along u and v.
   kind_type                kind6_ff;
   logic signed [VEC_W-1:0] d6_ff [3];
   logic signed [VEC_W-1:0] u6_ff [3];
   logic signed [VEC_W-1:0] v6_ff [3];
   logic [EXT_W-2:0]        ha6_ff, hb6_ff;
   logic signed [RES_W-1:0] rc6_ff [3];
   logic signed [65:0]      pu6_ff [3];
   logic signed [65:0]      pv6_ff [3];

   always_ff @(posedge clock) begin
      kind6_ff <= kind5_ff;
      ha6_ff   <= ha5_ff;
      hb6_ff   <= hb5_ff;
      for (int i = 0; i < 3; i++) begin
         d6_ff[i]  <= d5_ff[i];
         u6_ff[i]  <= u5_ff[i];
         v6_ff[i]  <= v5_ff[i];
         rc6_ff[i] <= rc5_ff[i];
         pu6_ff[i] <= 66'(p5_ff[i]) * 66'(u5_ff[i]);
         pv6_ff[i] <= 66'(p5_ff[i]) * 66'(v5_ff[i]);
      end
   end

   // Stage 7: plate coordinates clamped to the half extents.
   logic signed [37:0]      sa7, sb7;
   logic signed [VEC_W-1:0] a7_in, b7_in;

   always_comb begin
      sa7   = 38'(pu6_ff[0] >>> 30) + 38'(pu6_ff[1] >>> 30) + 38'(pu6_ff[2] >>> 30);
      sb7   = 38'(pv6_ff[0] >>> 30) + 38'(pv6_ff[1] >>> 30) + 38'(pv6_ff[2] >>> 30);
      a7_in = clip_half(sa7, ha6_ff);
      b7_in = clip_half(sb7, hb6_ff);
   end

   kind_type                kind7_ff;
   logic signed [VEC_W-1:0] d7_ff [3];
   logic signed [VEC_W-1:0] u7_ff [3];
   logic signed [VEC_W-1:0] v7_ff [3];
   logic signed [RES_W-1:0] rc7_ff [3];
   logic signed [VEC_W-1:0] a7_ff, b7_ff;

   always_ff @(posedge clock) begin
      kind7_ff <= kind6_ff;
      a7_ff    <= a7_in;
      b7_ff    <= b7_in;
      for (int i = 0; i < 3; i++) begin
         d7_ff[i]  <= d6_ff[i];
         u7_ff[i]  <= u6_ff[i];
         v7_ff[i]  <= v6_ff[i];
         rc7_ff[i] <= rc6_ff[i];
      end
   end

   // Stage 8: reconstruction products of the clamped plate point.
   kind_type                kind8_ff;
   logic signed [VEC_W-1:0] d8_ff [3];
   logic signed [RES_W-1:0] rc8_ff [3];
   logic signed [63:0]      ua8_ff [3];
   logic signed [63:0]      vb8_ff [3];

   always_ff @(posedge clock) begin
      kind8_ff <= kind7_ff;
      for (int i = 0; i < 3; i++) begin
         d8_ff[i]  <= d7_ff[i];
         rc8_ff[i] <= rc7_ff[i];
         ua8_ff[i] <= 64'(u7_ff[i]) * 64'(a7_ff);
         vb8_ff[i] <= 64'(v7_ff[i]) * 64'(b7_ff);
      end
   end

   // Stage 9: residual vector from the closest point to the sphere center.
   logic signed [RES_W-1:0] r9_in [3];
   logic signed [RES_W-1:0] r9_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         unique case (kind8_ff)
            KIND_SPHERE: begin
               r9_in[i] = 35'(d8_ff[i]);
            end
            KIND_CYL: begin
               r9_in[i] = rc8_ff[i];
            end
            default: begin
               r9_in[i] = 35'(ua8_ff[i] >>> 30) + 35'(vb8_ff[i] >>> 30) - 35'(d8_ff[i]);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         r9_ff[i] <= r9_in[i];
      end
   end

   assign resid.valid = vld_ff[GEOM_STAGES-1];
   assign resid.r0    = r9_ff[0];
   assign resid.r1    = r9_ff[1];
   assign resid.r2    = r9_ff[2];

endmodule

[hw/rtl/s2sd_sumsq.sv]
// Squared length of the residual vector with range check, two register stages.
// Depends on s2sd_pkg.
module s2sd_sumsq (
   input  logic                clock,
   input  logic                reset,
   input  s2sd_pkg::resid_type resid,
   output s2sd_pkg::rad_type   rad
);
   import s2sd_pkg::*;

   logic signed [RES_W-1:0] r_a [3];
   logic [RES_W-1:0]        mag [3];
   logic [2:0]              over_in;

   assign r_a[0] = resid.r0;
   assign r_a[1] = resid.r1;
   assign r_a[2] = resid.r2;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag[i]     = r_a[i][RES_W-1] ? RES_W'(-r_a[i]) : RES_W'(r_a[i]);
         over_in[i] = |mag[i][RES_W-1:ROOT_W];
      end
   end

   logic             vld10_ff, vld11_ff;
   logic [2:0]       over10_ff;
   logic [RAD_W-1:0] sq10_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld10_ff <= 1'b0;
         vld11_ff <= 1'b0;
      end else begin
         vld10_ff <= resid.valid;
         vld11_ff <= vld10_ff;
      end
   end

   always_ff @(posedge clock) begin
      over10_ff <= over_in;
      for (int i = 0; i < 3; i++) begin
         sq10_ff[i] <= RAD_W'(mag[i][ROOT_W-1:0]) * RAD_W'(mag[i][ROOT_W-1:0]);
      end
   end

   logic [RAD_W+1:0] tot_in;
   logic             sat_in;
   logic             sat11_ff;
   logic [RAD_W-1:0] tot11_ff;

   always_comb begin
      tot_in = (RAD_W+2)'(sq10_ff[0]) + (RAD_W+2)'(sq10_ff[1]) + (RAD_W+2)'(sq10_ff[2]);
      sat_in = (|over10_ff) | (|tot_in[RAD_W+1:RAD_W]);
   end

   always_ff @(posedge clock) begin
      sat11_ff <= sat_in;
      tot11_ff <= tot_in[RAD_W-1:0];
   end

   assign rad.valid    = vld11_ff;
   assign rad.sat      = sat11_ff;
   assign rad.radicand = tot11_ff;

endmodule

[hw/rtl/s2sd_isqrt.sv]
// Integer square root, one result bit per pipeline stage, floor of the exact root.
// Depends on s2sd_pkg.
module s2sd_isqrt (
   input  logic              clock,
   input  logic              reset,
   input  s2sd_pkg::rad_type rad,
   output s2sd_pkg::root_type root
);
   import s2sd_pkg::*;

   logic              vld_ff  [ROOT_W];
   logic              sat_ff  [ROOT_W];
   logic [RAD_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] q_ff    [ROOT_W];

   for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
      localparam int B = ROOT_W - 1 - j;

      logic              src_vld, src_sat;
      logic [RAD_W-1:0]  src_rem;
      logic [ROOT_W-1:0] src_q;
      logic [RAD_W+1:0]  cand;
      logic              take;

      if (j == 0) begin : g_first
         assign src_vld = rad.valid;
         assign src_sat = rad.sat;
         assign src_rem = rad.radicand;
         assign src_q   = '0;
      end else begin : g_next
         assign src_vld = vld_ff[j-1];
         assign src_sat = sat_ff[j-1];
         assign src_rem = rem_ff[j-1];
         assign src_q   = q_ff[j-1];
      end

      // Raising bit B of the root adds 2*q*2^B + 2^(2B) to its square.
      assign cand = ((RAD_W+2)'(src_q) << (B + 1)) + ((RAD_W+2)'(1) << (2 * B));
      assign take = (RAD_W+2)'(src_rem) >= cand;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else begin
            vld_ff[j] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         sat_ff[j] <= src_sat;
         if (take) begin
            rem_ff[j] <= src_rem - cand[RAD_W-1:0];
            q_ff[j]   <= src_q | (ROOT_W'(1) << B);
         end else begin
            rem_ff[j] <= src_rem;
            q_ff[j]   <= src_q;
         end
      end
   end

   assign root.valid = vld_ff[ROOT_W-1];
   assign root.sat   = sat_ff[ROOT_W-1];
   assign root.root  = q_ff[ROOT_W-1];

endmodule

[hw/rtl/sphere_to_shape_distance_core.sv]
// Sphere-to-shape distance core: one item per cycle, a result strobe for each start.
// The pipeline is 9 geometry stages, 2 sum-of-squares stages, 32 square-root stages and the
// output register; throughput is set by the fully pipelined datapath at one item per cycle.
// busy stays low; the receiver cannot stall. Synchronous reset clears all valid bits.
// Depends on s2sd_pkg, s2sd_geom, s2sd_sumsq, s2sd_isqrt and assert_macros.svh.
`include "assert_macros.svh"
module sphere_to_shape_distance_core #(
   parameter int COORD_WIDTH = s2sd_pkg::DEF_COORD_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [31:0] req_offset_x,
   input  logic [31:0] req_offset_y,
   input  logic [31:0] req_offset_z,
   input  logic [31:0] req_normal_x,
   input  logic [31:0] req_normal_y,
   input  logic [31:0] req_normal_z,
   input  logic [31:0] req_inplane_x,
   input  logic [31:0] req_inplane_y,
   input  logic [31:0] req_inplane_z,
   input  logic [30:0] req_extent_a,
   input  logic [30:0] req_extent_b,
   output logic        rsp_strobe,
   output logic [31:0] rsp_distance,
   output logic        rsp_saturated
);
   import s2sd_pkg::*;

   localparam int LATENCY = GEOM_STAGES + SUMSQ_STAGES + ROOT_W + 1;

   resid_type resid;
   rad_type   rad;
   root_type  root;

   assign busy = 1'b0;

   s2sd_geom #(.COORD_WIDTH(COORD_WIDTH)) u_geom (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_type  (req_type),
      .offset_x  (req_offset_x),
      .offset_y  (req_offset_y),
      .offset_z  (req_offset_z),
      .normal_x  (req_normal_x),
      .normal_y  (req_normal_y),
      .normal_z  (req_normal_z),
      .inplane_x (req_inplane_x),
      .inplane_y (req_inplane_y),
      .inplane_z (req_inplane_z),
      .extent_a  (req_extent_a),
      .extent_b  (req_extent_b),
      .resid     (resid)
   );

   s2sd_sumsq u_sumsq (
      .clock (clock),
      .reset (reset),
      .resid (resid),
      .rad   (rad)
   );

   s2sd_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .rad   (rad),
      .root  (root)
   );

   logic              strobe_ff;
   logic [ROOT_W-1:0] dist_ff, dist_in;
   logic              sat_ff;

   assign dist_in = root.sat ? '1 : root.root;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= root.valid;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      sat_ff  <= root.sat;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_distance  = dist_ff;
   assign rsp_saturated = sat_ff;

   `ASSERT_IMPLY(a_latency, clock, reset, start, ##LATENCY rsp_strobe)
   `ASSERT_IMPLY(a_no_spurious, clock, reset, rsp_strobe, $past(start, LATENCY))
   `ASSERT_IMPLY(a_sat_clamps, clock, reset, rsp_strobe && rsp_saturated, rsp_distance == '1)

endmodule
